// ===== rtl/core/tsd_pkg.sv =====
// ============================================================================
// tsd_pkg
// Types and constants shared by the trimmed squared distance block.
// ============================================================================
package tsd_pkg;

    localparam int ELEM_W = 16;
    localparam int SQ_W   = 32;
    localparam int DIST_W = 40;
    localparam int KEEP_W = 9;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 9'd128;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN,
        ST_PICK,
        ST_OUT
    } tsd_state_t;

endpackage

// ===== rtl/core/trimmed_squared_distance.sv =====
// ============================================================================
// trimmed_squared_distance
// Stores squared element differences in a memory and, on the last element,
// sums the keep_count smallest ones by repeated minimum selection.
// ============================================================================
// Throughput: one element per cycle while loading; one vector pair at a time.
// The selection is bound by the single memory read port: one scan per kept
// square. Reset clears the element count and restores keep_count to 128.
module trimmed_squared_distance
#(
    parameter int MAX_DIM = 256
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tsd_pkg::KEEP_W-1:0]        cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [tsd_pkg::ELEM_W-1:0] p_elem,
    input  logic signed [tsd_pkg::ELEM_W-1:0] q_elem,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tsd_pkg::DIST_W-1:0]        distance
);
    import tsd_pkg::*;

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);

    tsd_state_t state_reg, state_next;

    logic [KEEP_W-1:0] keep_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic              wr_pend_reg, last_pend_reg;
    logic [AW-1:0]     wr_addr_reg;
    logic [SQ_W-1:0]   sq;
    logic [SQ_W-1:0]   mem [MAX_DIM];
    logic [SQ_W-1:0]   rd_data_reg;
    logic [CW-1:0]     rd_idx_reg;
    logic              rd_ok_reg;
    logic [SQ_W-1:0]   prev_val_reg;
    logic [AW-1:0]     prev_idx_reg;
    logic              prev_ok_reg;
    logic [CW-1:0]     scan_reg;
    logic [CW-1:0]     picked_reg;
    logic [CW-1:0]     target_reg;
    logic [SQ_W-1:0]   min_reg;
    logic [AW-1:0]     min_idx_reg;
    logic              min_ok_reg;
    logic [DIST_W-1:0] sum_reg;
    logic              accept;
    logic              cand;
    logic              scan_done;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_LOAD) || last_pend_reg;
    assign out_valid = (state_reg == ST_OUT);
    assign distance = sum_reg;

    tsd_square u_square
    (
        .clk  (clk),
        .en   (accept),
        .p_in (p_elem),
        .q_in (q_elem),
        .sq   (sq)
    );

    always_comb
    begin
        count_next = count_reg;
        if (accept && (count_reg < CW'(MAX_DIM)))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // Squares already summed are ordered by value, then by address; a
    // candidate must come after the last one picked in that order.
    assign cand = rd_ok_reg && (!prev_ok_reg || (rd_data_reg > prev_val_reg) ||
                  ((rd_data_reg == prev_val_reg) &&
                   (rd_idx_reg[AW-1:0] > prev_idx_reg)));
    assign scan_done = rd_ok_reg && (rd_idx_reg == count_reg - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (last_pend_reg && !wr_pend_reg)
                begin
                    state_next = (target_reg == '0) ? ST_OUT : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_done) state_next = ST_PICK;
            end
            ST_PICK:
            begin
                state_next = (picked_reg + 1'b1 == target_reg) ? ST_OUT : ST_SCAN_RD;
            end
            ST_OUT:
            begin
                if (!out_stall) state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            mem[wr_addr_reg] <= sq;
        end
        rd_data_reg <= mem[scan_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            keep_reg      <= KEEP_RESET;
            count_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            last_pend_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            prev_val_reg  <= '0;
            prev_idx_reg  <= '0;
            prev_ok_reg   <= 1'b0;
            wr_addr_reg   <= '0;
            rd_idx_reg    <= '0;
            scan_reg      <= '0;
            picked_reg    <= '0;
            target_reg    <= '0;
            min_reg       <= '0;
            min_idx_reg   <= '0;
            min_ok_reg    <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                keep_reg <= cfg_wdata;
            end
            wr_pend_reg <= accept && (count_reg < CW'(MAX_DIM));
            wr_addr_reg <= count_reg[AW-1:0];
            count_reg   <= count_next;
            rd_ok_reg   <= 1'b0;
            if (accept && last)
            begin
                last_pend_reg <= 1'b1;
                target_reg <= (32'(keep_reg) < 32'(count_next)) ? CW'(keep_reg) : count_next;
                prev_ok_reg <= 1'b0;
                picked_reg <= '0;
                sum_reg    <= '0;
            end
            case (state_reg)
                ST_SCAN_RD:
                begin
                    scan_reg   <= '0;
                    min_ok_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    rd_ok_reg  <= 1'b1;
                    rd_idx_reg <= scan_reg;
                    if (scan_reg < count_reg - 1'b1)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    if (rd_ok_reg)
                    begin
                        rd_ok_reg <= !scan_done;
                    end
                    if (cand && (!min_ok_reg || rd_data_reg < min_reg))
                    begin
                        min_reg     <= rd_data_reg;
                        min_idx_reg <= rd_idx_reg[AW-1:0];
                        min_ok_reg  <= 1'b1;
                    end
                end
                ST_PICK:
                begin
                    prev_val_reg <= min_reg;
                    prev_idx_reg <= min_idx_reg;
                    prev_ok_reg  <= 1'b1;
                    sum_reg    <= sum_reg + DIST_W'(min_reg);
                    picked_reg <= picked_reg + 1'b1;
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        last_pend_reg <= 1'b0;
                        count_reg     <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/tsd_square.sv =====
// ============================================================================
// tsd_square
// Registered squared difference of two signed 16-bit elements.
// ============================================================================
module tsd_square
(
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [tsd_pkg::ELEM_W-1:0] p_in,
    input  logic signed [tsd_pkg::ELEM_W-1:0] q_in,
    output logic [tsd_pkg::SQ_W-1:0]      sq
);
    import tsd_pkg::*;

    logic signed [ELEM_W:0] diff;
    logic [ELEM_W-1:0]      mag;
    logic [SQ_W-1:0]        sq_reg;

    assign diff = {p_in[ELEM_W-1], p_in} - {q_in[ELEM_W-1], q_in};
    assign mag  = diff[ELEM_W] ? ELEM_W'(-diff) : diff[ELEM_W-1:0];
    assign sq   = sq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= SQ_W'(mag) * SQ_W'(mag);
        end
    end

endmodule
